FILE: rtl/som_pkg.sv
// Shared types and constants for the swarm omega steering block.
// No dependencies; imported by every other file of the block.
package som_pkg;

    localparam int unsigned BEARING_FRAC_BITS = 12;

    localparam int unsigned RANGE_W   = 13;
    localparam int unsigned BEARING_W = 15;
    localparam int unsigned LIGHT_W   = 8;
    localparam int unsigned SPEED_W   = 16;
    localparam int unsigned OMEGA_W   = 16;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned AVOID_W   = 17;
    localparam int unsigned SUM_W     = 20;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CFG_ADDR_W = 3;

    // pi in Q28, floored; shifted down it gives the front half-angle
    localparam longint unsigned PI_Q28_FLOOR = 64'd843314856;
    localparam logic [BEARING_W:0] HALF_PI =
        (BEARING_W+1)'(PI_Q28_FLOOR >> (29 - BEARING_FRAC_BITS));
    // off-center threshold per live neighbor: ceil(0.1 * 2^F)
    localparam logic [SUM_W:0] CENTER_THR =
        (SUM_W+1)'(((64'd1 << BEARING_FRAC_BITS) + 64'd9) / 64'd10);

    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((1 << (SUM_W-1)) - 1);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W+1)'(1 << (SUM_W-1));

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WHEEL_SPEED   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_NORMAL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_LIGHT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OMEGA_TICKS   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAILURE_TICK  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAIL_KIND     = 3'd5;

    // per-tick accumulator view handed from the accumulator to the decision logic
    typedef struct packed {
        logic                       found_near;
        logic [RANGE_W-1:0]         nearest_range;
        logic                       nearest_on_right;
        logic signed [SUM_W-1:0]    bearing_sum;
    } t_acc;

endpackage

FILE: rtl/som_accum.sv
// Per-tick neighbor accumulator: nearest-in-front search and bearing sum.
// Depends on som_pkg.
module som_accum #(
    parameter int unsigned MAX_NEIGHBORS = 64,
    parameter int unsigned COUNT_W       = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_last,
    input  logic                                 i_no_neighbor,
    input  logic [som_pkg::RANGE_W-1:0]          i_range_mm,
    input  logic signed [som_pkg::BEARING_W-1:0] i_bearing,
    input  logic                                 i_neighbor_down,
    input  logic [som_pkg::LIGHT_W-1:0]          i_light_mask,
    input  logic [som_pkg::RANGE_W-1:0]          i_radius_normal,
    input  logic [som_pkg::RANGE_W-1:0]          i_radius_light,
    output som_pkg::t_acc                        o_acc,
    output logic [COUNT_W-1:0]                   o_count
);
    import som_pkg::*;

    t_acc                   r_acc;
    t_acc                   n_acc;
    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     n_count;
    logic [RANGE_W-1:0]     radius;
    logic signed [BEARING_W:0] b_ext;
    logic [BEARING_W:0]     b_mag;
    logic                   hit;
    logic signed [SUM_W:0]  sum_wide;

    assign radius   = (i_light_mask != '0) ? i_radius_light : i_radius_normal;
    assign b_ext    = (BEARING_W+1)'(i_bearing);
    assign b_mag    = b_ext[BEARING_W] ? (BEARING_W+1)'(-b_ext) : (BEARING_W+1)'(b_ext);
    assign hit      = !i_no_neighbor && (i_range_mm < radius) && (b_mag <= HALF_PI);
    assign sum_wide = (SUM_W+1)'(r_acc.bearing_sum) + (SUM_W+1)'(i_bearing);

    always_comb begin
        n_acc   = r_acc;
        n_count = r_count;
        if (hit && (!r_acc.found_near || i_range_mm < r_acc.nearest_range)) begin
            n_acc.found_near       = 1'b1;
            n_acc.nearest_range    = i_range_mm;
            n_acc.nearest_on_right = i_bearing[BEARING_W-1];
        end
        if (!i_no_neighbor && !i_neighbor_down && (r_count < COUNT_W'(MAX_NEIGHBORS))) begin
            priority if (sum_wide > SUM_MAX) begin
                n_acc.bearing_sum = SUM_MAX[SUM_W-1:0];
            end else if (sum_wide < SUM_MIN) begin
                n_acc.bearing_sum = SUM_MIN[SUM_W-1:0];
            end else begin
                n_acc.bearing_sum = sum_wide[SUM_W-1:0];
            end
            n_count = r_count + COUNT_W'(1);
        end
    end

    assign o_acc   = n_acc;
    assign o_count = n_count;

    // clear at the end of every tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
        end else if (i_en) begin
            if (i_last) begin
                r_acc   <= '0;
                r_count <= '0;
            end else begin
                r_acc   <= n_acc;
                r_count <= n_count;
            end
        end
    end

endmodule

FILE: rtl/som_decide.sv
// End-of-tick decision: avoid, steer to center, go straight or stop; tick counters.
// Depends on som_pkg.
module som_decide #(
    parameter int unsigned COUNT_W = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  som_pkg::t_acc                  i_acc,
    input  logic [COUNT_W-1:0]             i_count,
    input  logic [som_pkg::SPEED_W-1:0]    i_wheel_speed,
    input  logic [som_pkg::OMEGA_W-1:0]    i_omega_ticks,
    input  logic [som_pkg::TICK_W-1:0]     i_failure_tick,
    input  logic                           i_fail_kind,
    output logic [som_pkg::SPEED_W-1:0]    o_left,
    output logic [som_pkg::SPEED_W-1:0]    o_right,
    output logic                           o_failed
);
    import som_pkg::*;

    logic [TICK_W-1:0]  r_tick;
    logic [TICK_W-1:0]  n_tick;
    logic [AVOID_W-1:0] r_since;
    logic [AVOID_W-1:0] n_since;
    logic               r_failed;
    logic               n_failed;
    logic [SUM_W:0]     sum_mag;
    logic [SUM_W:0]     thr_prod;
    logic               off_centre;

    assign sum_mag  = i_acc.bearing_sum[SUM_W-1]
                    ? (SUM_W+1)'(-(SUM_W+1)'(i_acc.bearing_sum))
                    : (SUM_W+1)'(i_acc.bearing_sum);
    assign thr_prod = (SUM_W+1)'(CENTER_THR * (SUM_W+1)'(i_count));
    assign off_centre = (i_count != '0) && (sum_mag > thr_prod);

    always_comb begin
        n_failed = (r_tick == i_failure_tick) ? i_fail_kind : r_failed;
        n_since  = r_since;
        o_left   = '0;
        o_right  = '0;
        if (!n_failed) begin
            priority if (i_acc.found_near) begin
                // turn away from the nearest neighbor in front
                if (i_acc.nearest_on_right) o_right = i_wheel_speed;
                else                        o_left  = i_wheel_speed;
                n_since = '0;
            end else if (r_since > AVOID_W'(i_omega_ticks)) begin
                if (off_centre) begin
                    if (i_acc.bearing_sum[SUM_W-1]) o_left  = i_wheel_speed;
                    else                            o_right = i_wheel_speed;
                end else begin
                    o_left  = i_wheel_speed;
                    o_right = i_wheel_speed;
                end
            end else begin
                o_left  = i_wheel_speed;
                o_right = i_wheel_speed;
                if (r_since != '1) n_since = r_since + AVOID_W'(1);
            end
        end
        n_tick = (r_tick != '1) ? r_tick + TICK_W'(1) : r_tick;
    end

    assign o_failed = n_failed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_since  <= '0;
            r_failed <= 1'b0;
        end else if (i_en) begin
            r_tick   <= n_tick;
            r_since  <= n_since;
            r_failed <= n_failed;
        end
    end

endmodule

FILE: rtl/swarm_omega_steering_top.sv
// Top level of the swarm omega steering controller: stream ports, config registers,
// input and result registers. Depends on som_pkg, som_accum and som_decide.
//
// Usage:
//   Slave stream: one neighbor reading per beat. tlast marks the final beat of a
//   control tick; tuser set means the beat carries no reading, and with tlast it
//   still closes the tick. Master stream: one wheel command beat per control tick.
//   Config port: write i_cfg_wdata into register i_cfg_addr while i_cfg_we is high;
//   indexes above the fail kind register are dropped. Write only while idle.
// Path: an accepted beat is held in the input register, then folded into the tick
//   accumulators; a closing beat also loads its command into the result register.
// Throughput: one beat per cycle sustained unless a tick-closing beat waits on a
//   pending command; the only loop is the accumulator update (one add, saturate and
//   compare) and the end-of-tick decision.
// Reset: synchronous, active low; clears counters, accumulators, failure state and
//   loads the register defaults (speed 250, failure tick all ones).
// Stall: a waiting command holds in the result register; readings keep flowing
//   into the accumulators, and only a further tick-closing beat waits in the
//   input register until the command is taken.
module swarm_omega_steering_top #(
    parameter int unsigned MAX_NEIGHBORS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [12:0] range_mm, [27:13] bearing, [28] neighbor_down, [36:29] light_mask
    input  logic [39:0]  i_s_axis_tdata,
    // [0] no_neighbor
    input  logic         i_s_axis_tuser,
    input  logic         i_s_axis_tlast,
    // master stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [15:0] left_speed, [31:16] right_speed, [32] power_failed
    output logic [39:0]  o_m_axis_tdata,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [som_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [som_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import som_pkg::*;

    localparam int unsigned COUNT_W = $clog2(MAX_NEIGHBORS + 1);

    // configuration
    logic [SPEED_W-1:0] r_wheel_speed;
    logic [RANGE_W-1:0] r_radius_normal;
    logic [RANGE_W-1:0] r_radius_light;
    logic [OMEGA_W-1:0] r_omega_ticks;
    logic [TICK_W-1:0]  r_failure_tick;
    logic               r_fail_kind;

    // input register
    logic                        r_in_valid;
    logic [RANGE_W-1:0]          r_range_mm;
    logic signed [BEARING_W-1:0] r_bearing;
    logic                        r_down;
    logic                        r_no_neighbor;
    logic                        r_last;
    logic [LIGHT_W-1:0]          r_light;

    // result register
    logic                r_out_valid;
    logic [SPEED_W-1:0]  r_left;
    logic [SPEED_W-1:0]  r_right;
    logic                r_failed_out;

    logic               out_free;
    logic               proc_en;
    logic               in_take;
    t_acc               acc;
    logic [COUNT_W-1:0] acc_count;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic               failed;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    // readings advance freely; a tick-closing beat needs room for its command
    assign proc_en         = r_in_valid && (!r_last || out_free);
    assign o_s_axis_tready = !r_in_valid || proc_en;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_speed   <= SPEED_W'(250);
            r_radius_normal <= '0;
            r_radius_light  <= '0;
            r_omega_ticks   <= '0;
            r_failure_tick  <= '1;
            r_fail_kind     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WHEEL_SPEED:   r_wheel_speed   <= i_cfg_wdata[SPEED_W-1:0];
                CFG_RADIUS_NORMAL: r_radius_normal <= i_cfg_wdata[RANGE_W-1:0];
                CFG_RADIUS_LIGHT:  r_radius_light  <= i_cfg_wdata[RANGE_W-1:0];
                CFG_OMEGA_TICKS:   r_omega_ticks   <= i_cfg_wdata[OMEGA_W-1:0];
                CFG_FAILURE_TICK:  r_failure_tick  <= i_cfg_wdata[TICK_W-1:0];
                CFG_FAIL_KIND:     r_fail_kind     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register: hold the beat until the accumulators take it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_en) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_range_mm    <= i_s_axis_tdata[12:0];
            r_bearing     <= i_s_axis_tdata[27:13];
            r_down        <= i_s_axis_tdata[28];
            r_light       <= i_s_axis_tdata[36:29];
            r_no_neighbor <= i_s_axis_tuser;
            r_last        <= i_s_axis_tlast;
        end
    end

    som_accum #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .COUNT_W       (COUNT_W)
    ) u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (proc_en),
        .i_last          (r_last),
        .i_no_neighbor   (r_no_neighbor),
        .i_range_mm      (r_range_mm),
        .i_bearing       (r_bearing),
        .i_neighbor_down (r_down),
        .i_light_mask    (r_light),
        .i_radius_normal (r_radius_normal),
        .i_radius_light  (r_radius_light),
        .o_acc           (acc),
        .o_count         (acc_count)
    );

    som_decide #(
        .COUNT_W (COUNT_W)
    ) u_decide (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (proc_en && r_last),
        .i_acc          (acc),
        .i_count        (acc_count),
        .i_wheel_speed  (r_wheel_speed),
        .i_omega_ticks  (r_omega_ticks),
        .i_failure_tick (r_failure_tick),
        .i_fail_kind    (r_fail_kind),
        .o_left         (left_speed),
        .o_right        (right_speed),
        .o_failed       (failed)
    );

    // result register: hold the command until the receiver takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en && r_last) begin
            r_left       <= left_speed;
            r_right      <= right_speed;
            r_failed_out <= failed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_failed_out, r_right, r_left};

endmodule

FILE: test/tb.sv
// Self-checking bench for swarm_omega_steering_top: streams neighbor readings, predicts
// each wheel command from a behavioral model of the tick logic and checks the master side.
// Depends on som_pkg (register indexes, widths) and the RTL of the block.
module tb;

    // bench limits and timing
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_BEATS  = 290;   // reading beats per random phase, six phases

    // fixed-point constants at 12 fraction bits
    localparam int FRONT_LIM   = 6433;   // floor(pi/2 * 4096): "in front" bound
    localparam int CENTER_STEP = 410;    // ceil(0.1 * 4096): off-center step per neighbor
    localparam int SUM_HI      = 524287;
    localparam int SUM_LO      = -524288;
    localparam int MAX_NB      = 64;
    localparam int unsigned AVOID_SAT = 131071;

    // one neighbor reading, as carried by a slave beat
    typedef struct packed {
        logic [12:0] range_mm;
        logic [14:0] bearing;
        logic        down;
        logic [7:0]  light;
        logic        no_nb;
        logic        last;
    } t_reading;

    // one wheel command, as carried by a master beat
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        failed;
    } t_wheel_cmd;

    // directed row: reading, optional typed command, reconfigure before the row
    typedef struct packed {
        t_reading   rd;
        logic       pinned;
        logic       reconf;
        t_wheel_cmd want;
    } t_dir_row;

    // Directed rows. The first ones run at reset defaults (speed 250, radii 0, omega 0);
    // the reconfigure row switches to speed 0xFFFF, radius 8191 dark / 100 lit, omega 3.
    localparam t_dir_row DIRECTED [20] = '{
        // empty tick right after reset: drive straight, start counting
        '{'{13'd0, 15'd0, 1'b0, 8'h00, 1'b1, 1'b1}, 1'b1, 1'b0, '{16'd250, 16'd250, 1'b0}},
        // count now exceeds omega 0, but no live neighbors: still straight
        '{'{13'd0, 15'd0, 1'b0, 8'h00, 1'b1, 1'b1}, 1'b1, 1'b0, '{16'd250, 16'd250, 1'b0}},
        // field extremes; largest positive bearing is the only live one
        '{'{13'd0, 15'h3FFF, 1'b0, 8'hFF, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
        '{'{13'h1FFF, 15'h4000, 1'b1, 8'h00, 1'b0, 1'b1}, 1'b1, 1'b0, '{16'd0, 16'd250, 1'b0}},
        // front edge inside radius, on the left: turn away to the right
        '{'{13'd8190, 15'd6433, 1'b0, 8'h00, 1'b0, 1'b1}, 1'b1, 1'b1,
          '{16'hFFFF, 16'd0, 1'b0}},
        // just outside front; lit radius excludes the next; tie keeps the first (right)
        '{'{13'd500, 15'd6434, 1'b0, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
        '{'{13'd500, 15'(-6433), 1'b0, 8'h01, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
        '{'{13'd99, 15'(-1), 1'b1, 8'h80, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
        '{'{13'd99, 15'd5, 1'b0, 8'h80, 1'b0, 1'b1}, 1'b1, 1'b0, '{16'd0, 16'hFFFF, 1'b0}},
        // empty tick with near-looking fields: fields must be ignored
        '{'{13'd0, 15'd0, 1'b0, 8'hFF, 1'b1, 1'b1}, 1'b1, 1'b0,
          '{16'hFFFF, 16'hFFFF, 1'b0}},
        '{'{13'd0, 15'd0, 1'b0, 8'h00, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
        '{'{13'd0, 15'd0, 1'b0, 8'h00, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
        '{'{13'd0, 15'd0, 1'b0, 8'h00, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
        // center steering around the threshold; range equal to radius is not near
        '{'{13'h1FFF, 15'(-410), 1'b0, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
        '{'{13'h1FFF, 15'(-1), 1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
        '{'{13'h1FFF, 15'(-411), 1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
        '{'{13'h1FFF, 15'd410, 1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
        // mid-tick empty beat is dropped, then a far-left neighbor
        '{'{13'd5, 15'd100, 1'b0, 8'h00, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
        '{'{13'h1FFF, 15'd12868, 1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
        // only neighbor is down: no live neighbors while steering
        '{'{13'h1FFF, 15'(-12868), 1'b1, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0}
    };

    // DUT ports, every input driven to a known value from time zero
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    // [12:0] range_mm, [27:13] bearing, [28] neighbor_down, [36:29] light_mask
    logic [39:0]                    i_s_axis_tdata = '0;
    // [0] no_neighbor
    logic                           i_s_axis_tuser = 1'b0;
    logic                           i_s_axis_tlast = 1'b0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    // [15:0] left_speed, [31:16] right_speed, [32] power_failed
    logic [39:0]                    o_m_axis_tdata;
    logic                           i_cfg_we = 1'b0;
    logic [som_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [som_pkg::CFG_W-1:0]      i_cfg_wdata = '0;

    swarm_omega_steering_top DUT (.*);

    // shadow registers, reset values
    logic [15:0] cfg_speed     = 16'd250;
    logic [12:0] cfg_rad_dark  = '0;
    logic [12:0] cfg_rad_lit   = '0;
    logic [15:0] cfg_omega     = '0;
    logic [31:0] cfg_fail_at   = 32'hFFFF_FFFF;
    logic        cfg_fail_kind = 1'b0;

    // controller state as the predictor sees it
    logic [31:0] cur_tick   = '0;
    int unsigned since_turn = 0;
    logic        dead       = 1'b0;
    logic        near_seen  = 1'b0;
    logic [12:0] near_mm    = '0;
    logic        near_right = 1'b0;
    int          bear_acc   = 0;
    int          live_n     = 0;

    // bench bookkeeping
    t_wheel_cmd  wheel_cmd_q[$];
    int          mismatches = 0;
    int          cmds_checked = 0;
    int          n_avoid = 0;
    int          n_centre = 0;
    int          n_dead = 0;
    int          readings_sent = 0;
    int          cycles = 0;
    int          src_gap = 27;
    int          snk_gap = 87;
    logic        pin_on = 1'b0;
    t_wheel_cmd  pin_cmd = '0;

    // Fold one accepted beat into the tick state; on the closing beat decide the command.
    function automatic void predict_wheel_cmd(input t_reading r, output bit has_cmd,
                                              output t_wheel_cmd cmd);
        int          b;
        int          mag;
        int          s;
        int unsigned radius;
        has_cmd = 1'b0;
        cmd = '0;
        if (!r.no_nb) begin
            b = 32'($signed(r.bearing));
            mag = (b < 0) ? -b : b;
            radius = (r.light != 8'h00) ? 32'(cfg_rad_lit) : 32'(cfg_rad_dark);
            if (32'(r.range_mm) < radius && mag <= FRONT_LIM) begin
                // strict compare: on a tie the earlier reading stays nearest
                if (!near_seen || r.range_mm < near_mm) begin
                    near_seen = 1'b1;
                    near_mm = r.range_mm;
                    near_right = (b < 0);
                end
            end
            if (!r.down && live_n < MAX_NB) begin
                s = bear_acc + b;
                if (s > SUM_HI) s = SUM_HI;
                if (s < SUM_LO) s = SUM_LO;
                bear_acc = s;
                live_n++;
            end
        end
        if (!r.last) return;

        has_cmd = 1'b1;
        if (cur_tick == cfg_fail_at) dead = cfg_fail_kind;
        if (!dead) begin
            if (near_seen) begin
                if (near_right) cmd.right = cfg_speed;
                else cmd.left = cfg_speed;
                since_turn = 0;
                n_avoid++;
            end else if (since_turn > 32'(cfg_omega)) begin
                mag = (bear_acc < 0) ? -bear_acc : bear_acc;
                if (live_n != 0 && mag > CENTER_STEP * live_n) begin
                    if (bear_acc < 0) cmd.left = cfg_speed;
                    else cmd.right = cfg_speed;
                    n_centre++;
                end else begin
                    cmd.left = cfg_speed;
                    cmd.right = cfg_speed;
                end
            end else begin
                cmd.left = cfg_speed;
                cmd.right = cfg_speed;
                if (since_turn < AVOID_SAT) since_turn++;
            end
        end else begin
            n_dead++;
        end
        cmd.failed = dead;
        if (cur_tick != 32'hFFFF_FFFF) cur_tick++;
        near_seen = 1'b0;
        near_mm = '0;
        near_right = 1'b0;
        bear_acc = 0;
        live_n = 0;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // free-running clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle at the falling edge
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= snk_gap);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d commands pending",
                     cycles, wheel_cmd_q.size());
            $display("swarm_omega_steering_top verification failed");
            $finish;
        end
    end

    // Monitor: check the master beat first, then fold the slave beat of the same edge.
    // A command always trails the acceptance of its closing beat, so the order is safe.
    always @(posedge i_clk) begin : beat_monitor
        t_wheel_cmd got;
        t_wheel_cmd want;
        t_wheel_cmd pred;
        t_reading   rd;
        bit         has_cmd;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.left = o_m_axis_tdata[15:0];
                got.right = o_m_axis_tdata[31:16];
                got.failed = o_m_axis_tdata[32];
                cmds_checked++;
                if (wheel_cmd_q.size() == 0) begin
                    note_mismatch($sformatf("command L=%0d R=%0d F=%0b with none pending",
                                            got.left, got.right, got.failed));
                end else begin
                    want = wheel_cmd_q.pop_front();
                    if (got.left !== want.left || got.right !== want.right
                        || got.failed !== want.failed)
                        note_mismatch($sformatf(
                            "command %0d: expected L=%0d R=%0d F=%0b, got L=%0d R=%0d F=%0b",
                            cmds_checked, want.left, want.right, want.failed,
                            got.left, got.right, got.failed));
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                rd.range_mm = i_s_axis_tdata[12:0];
                rd.bearing = i_s_axis_tdata[27:13];
                rd.down = i_s_axis_tdata[28];
                rd.light = i_s_axis_tdata[36:29];
                rd.no_nb = i_s_axis_tuser;
                rd.last = i_s_axis_tlast;
                predict_wheel_cmd(rd, has_cmd, pred);
                // a typed-in command from the directed table overrides the prediction
                if (has_cmd) wheel_cmd_q.push_back(pin_on ? pin_cmd : pred);
            end
        end
    end

    // Drive one beat from a falling edge; hold it until accepted, return at a falling edge.
    task automatic send_beat(input t_reading r, input logic pinned, input t_wheel_cmd want);
        while ($urandom_range(99) < src_gap) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata = {3'b000, r.light, r.down, r.bearing, r.range_mm};
        i_s_axis_tuser = r.no_nb;
        i_s_axis_tlast = r.last;
        pin_on = pinned;
        pin_cmd = want;
        i_s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the slave side idle until every command is back, then let the pipe settle.
    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        pin_on = 1'b0;
        while (wheel_cmd_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One register write at a falling edge; mirror it into the shadow registers.
    task automatic write_reg(input logic [som_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        case (idx)
            som_pkg::CFG_WHEEL_SPEED:   cfg_speed = val[15:0];
            som_pkg::CFG_RADIUS_NORMAL: cfg_rad_dark = val[12:0];
            som_pkg::CFG_RADIUS_LIGHT:  cfg_rad_lit = val[12:0];
            som_pkg::CFG_OMEGA_TICKS:   cfg_omega = val[15:0];
            som_pkg::CFG_FAILURE_TICK:  cfg_fail_at = val;
            som_pkg::CFG_FAIL_KIND:     cfg_fail_kind = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One random control tick. Mostly a few readings with a shared light mask; now and
    // then an empty tick, or a crowded one with same-side extreme bearings that can overflow
    // the neighbor limit and saturate the bearing sum. Stray empty beats mid-tick are noise.
    task automatic send_tick();
        int       kind;
        int       n;
        int       sgn;
        int       bv;
        logic [7:0] tick_light;
        t_reading r;
        kind = $urandom_range(99);
        if (kind < 8) begin
            r = t_reading'({$urandom, $urandom});
            r.no_nb = 1'b1;
            r.last = 1'b1;
            send_beat(r, 1'b0, '0);
            readings_sent++;
            return;
        end
        n = (kind < 11) ? $urandom_range(60, 80) : $urandom_range(1, 8);
        sgn = $urandom_range(1) ? 1 : -1;
        tick_light = $urandom_range(1) ? 8'h00 : 8'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) begin
                r = t_reading'({$urandom, $urandom});
                r.no_nb = 1'b1;
                r.last = 1'b0;
                send_beat(r, 1'b0, '0);
            end
            case ($urandom_range(3))
                0: r.range_mm = $urandom_range(1) ? 13'h1FFF : 13'd0;
                1: r.range_mm = 13'($urandom_range(0, 600));
                2: r.range_mm = 13'($urandom_range(0, 3000));
                default: r.range_mm = 13'($urandom_range(0, 8191));
            endcase
            if (kind < 11) begin
                bv = sgn * int'($urandom_range(12000, 16383));
            end else begin
                case ($urandom_range(9))
                    0: bv = 32'($signed(15'($urandom)));
                    1: bv = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(6432, 6435));
                    default: bv = int'($urandom_range(25736)) - 12868;
                endcase
            end
            r.bearing = 15'(bv);
            r.down = ($urandom_range(5) == 0);
            r.light = ($urandom_range(15) == 0) ? 8'($urandom) : tick_light;
            r.no_nb = 1'b0;
            r.last = (i == n - 1);
            send_beat(r, 1'b0, '0);
            readings_sent++;
        end
    endtask

    initial begin : stimulus
        logic [15:0] v_speed;
        logic [12:0] v_dark;
        logic [12:0] v_lit;
        logic [15:0] v_omega;
        logic [31:0] v_fail_at;
        logic        v_kind;
        int          target;

        // hold reset from time zero, release at a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows: reset defaults first, then one reconfiguration
        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].reconf) begin
                drain();
                write_reg(som_pkg::CFG_WHEEL_SPEED, 32'h0000_FFFF);
                write_reg(som_pkg::CFG_RADIUS_NORMAL, 32'd8191);
                write_reg(som_pkg::CFG_RADIUS_LIGHT, 32'd100);
                write_reg(som_pkg::CFG_OMEGA_TICKS, 32'd3);
            end
            send_beat(DIRECTED[k].rd, DIRECTED[k].pinned, DIRECTED[k].want);
        end

        // Random phases: two with a bursty sender and a slow receiver, two the other way
        // round, two with no gaps. Each phase rewrites every register while idle; the
        // last one arms a power failure a few ticks ahead, since it cannot be undone.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            src_gap = (ph < 2) ? 27 : (ph < 4) ? 87 : 0;
            snk_gap = (ph < 2) ? 87 : (ph < 4) ? 27 : 0;
            v_speed = 16'($urandom_range(0, 65535));
            v_dark = 13'($urandom_range(0, 3000));
            v_lit = 13'($urandom_range(0, 3000));
            v_omega = 16'($urandom_range(0, 5));
            v_fail_at = 32'hFFFF_FFFF;
            v_kind = 1'b0;
            case (ph)
                0: begin
                    // failure tick hit with the keep-functioning kind: no effect
                    v_speed = 16'd0;
                    v_dark = 13'h1FFF;
                    v_lit = 13'd0;
                    v_omega = 16'd0;
                    v_fail_at = cur_tick + 32'd5;
                end
                1: begin
                    v_speed = 16'hFFFF;
                    v_dark = 13'($urandom_range(0, 8191));
                    v_lit = 13'($urandom_range(0, 8191));
                    v_omega = 16'hFFFF;
                end
                2: begin
                    v_dark = 13'($urandom_range(200, 1500));
                    v_lit = 13'($urandom_range(1500, 8191));
                    v_omega = 16'd2;
                    v_kind = 1'b1;
                end
                3: begin
                    v_dark = 13'd0;
                    v_lit = 13'h1FFF;
                    v_omega = 16'd1;
                end
                5: begin
                    v_omega = 16'd0;
                    v_fail_at = cur_tick + 32'($urandom_range(2, 25));
                    v_kind = 1'b1;
                end
                default: ;
            endcase
            write_reg(som_pkg::CFG_WHEEL_SPEED, {16'h0000, v_speed});
            write_reg(som_pkg::CFG_RADIUS_NORMAL, {19'h0, v_dark});
            write_reg(som_pkg::CFG_RADIUS_LIGHT, {19'h0, v_lit});
            write_reg(som_pkg::CFG_OMEGA_TICKS, {16'h0000, v_omega});
            write_reg(som_pkg::CFG_FAILURE_TICK, v_fail_at);
            write_reg(som_pkg::CFG_FAIL_KIND, {31'h0, v_kind});
            target = readings_sent + PHASE_BEATS;
            while (readings_sent < target) send_tick();
        end

        // wait out every pending command, then let the pipe settle
        drain();
        if (wheel_cmd_q.size() != 0) mismatches += wheel_cmd_q.size();
        $display("covered %0d ticks (%0d random reading beats), %0d commands compared",
                 cur_tick, readings_sent, cmds_checked);
        $display("turn-aways %0d, center steers %0d, powered-down ticks %0d, mismatches %0d",
                 n_avoid, n_centre, n_dead, mismatches);
        if (mismatches == 0) begin
            $display("swarm_omega_steering_top verification clean");
        end else begin
            $display("swarm_omega_steering_top verification failed");
        end
        $finish;
    end

endmodule
